// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off while rst is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/i2c_ee_pkg.sv
// ---------------------------------------------------------------------------
// i2c_ee_pkg
// Types and constants of the serial EEPROM bus master: commands, bus phases,
// protocol stages and reset values of the configuration registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2c_ee_pkg;

  // page buffer and transfer limits
  localparam int PAGE_BYTES     = 8;
  localparam int MAX_READ_BYTES = 256;
  localparam int BUF_DEPTH      = 8;
  localparam int BUF_IDX_W      = $clog2(BUF_DEPTH);

  // configuration register reset values
  localparam logic [6:0]  DEV_ADDR_RESET    = 7'd80;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd200;

  // configuration register indexes
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // commands of an input item
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_LOAD      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_CUR_READ  = 3'd3,
    CMD_RAND_READ = 3'd4,
    CMD_SEQ_READ  = 3'd5
  } cmd_t;

  // bus phase within a stage
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_TXL   = 4'd2,
    PH_TXH   = 4'd3,
    PH_AKL   = 4'd4,
    PH_AKH   = 4'd5,
    PH_RXL   = 4'd6,
    PH_RXH   = 4'd7,
    PH_MKL   = 4'd8,
    PH_MKH   = 4'd9,
    PH_RSL   = 4'd10,
    PH_RSH   = 4'd11,
    PH_SPA   = 4'd12,
    PH_SPB   = 4'd13,
    PH_SPC   = 4'd14
  } phase_t;

  // protocol stage: device write address, word address, data, device read address
  typedef enum logic [1:0] {
    STG_DEVW = 2'd0,
    STG_WORD = 2'd1,
    STG_BODY = 2'd2,
    STG_DEVR = 2'd3
  } stage_t;

  // an aborted transfer runs its stop in the word stage code
  localparam stage_t STG_ERR = STG_WORD;

endpackage

// File: rtl/core/i2c_ee_req_if.sv
// ---------------------------------------------------------------------------
// i2c_ee_req_if
// Request channel: one bus phase tick or, while idle, one command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2c_ee_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] word_address;
  logic [7:0] write_data;
  logic [2:0] load_index;
  logic [8:0] length;
  logic       sda_in;

  modport source (
    output valid, command, word_address, write_data, load_index, length, sda_in,
    input  ready
  );

  modport sink (
    input  valid, command, word_address, write_data, load_index, length, sda_in,
    output ready
  );
endinterface

// File: rtl/core/i2c_ee_res_if.sv
// ---------------------------------------------------------------------------
// i2c_ee_res_if
// Result channel: bus line levels, received byte and transfer status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2c_ee_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       busy_res;
  logic       ack_error;
  logic       done_res;

  modport source (
    output valid, scl_level, sda_release, read_valid, read_data, read_last,
           busy_res, ack_error, done_res,
    input  ready
  );

  modport sink (
    input  valid, scl_level, sda_release, read_valid, read_data, read_last,
           busy_res, ack_error, done_res,
    output ready
  );
endinterface

// File: rtl/core/i2c_eeprom_master_top.sv
// ---------------------------------------------------------------------------
// i2c_eeprom_master_top
// Phase-level bus master for a small serial EEPROM: page write, current,
// random and sequential read, with acknowledge timeout and stop on abort.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      carries
//  request   in   valid/ready    command, word_address, write_data,
//                                load_index, length, sda_in
//  result    out  valid/ready    scl_level, sda_release, read_valid,
//                                read_data, read_last, busy_res, ack_error,
//                                done_res
//  cfg       in   cfg_wr_en      cfg_index, cfg_wr_data (no read-back)
//
//  one request transfer per cycle when not stalled; its result is in the output
//  register the cycle after, set by one pass of the phase sequencer logic
//  the request side stays ready while the output register is empty or its
//  result is taken in the same cycle
//  rst is synchronous: sequencer idle, configuration registers at their reset
//  values, result register empty, page buffer contents undefined until loaded
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_eeprom_master_top
  import i2c_ee_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  i2c_ee_req_if.sink       request,
  i2c_ee_res_if.source     result,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_wr_data
);

  // configuration registers
  logic [6:0]  device_address;
  logic [15:0] ack_timeout;

  // sequencer state
  phase_t              sub, sub_next;
  stage_t              stage, stage_next;
  logic                op_write, op_write_next;
  logic [3:0]          bit_count, bit_count_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [8:0]          bytes_left, bytes_left_next;
  logic [BUF_IDX_W-1:0] buffer_index, buffer_index_next;
  logic [7:0]          target_address, target_address_next;
  logic [15:0]         timeout_count, timeout_count_next;
  logic [7:0]          page_buffer [BUF_DEPTH];

  // result register
  logic       out_valid;
  logic       scl_r, rel_r, rv_r, rl_r, busy_r, err_r, done_r;
  logic [7:0] rd_r;

  // combinational result of the current item
  logic       scl_c, rel_c, rv_c, rl_c, err_c, done_c;
  logic [7:0] rd_c;

  logic                 accept;
  logic                 buf_we;
  logic [BUF_IDX_W-1:0] buf_rd_idx;
  logic [BUF_IDX_W-1:0] idx_inc;
  logic [3:0]           bc_inc;
  logic [8:0]           bl_dec;
  logic [7:0]           shift_in;
  logic [8:0]           wr_len;
  logic [8:0]           rd_len;
  cmd_t                 cmd;

  assign accept        = request.valid && request.ready;
  assign request.ready = !out_valid || result.ready;
  assign cmd           = cmd_t'(request.command);

  assign idx_inc    = buffer_index + BUF_IDX_W'(1);
  assign bc_inc     = bit_count + 4'd1;
  assign bl_dec     = (bytes_left != 9'd0) ? bytes_left - 9'd1 : bytes_left;
  assign shift_in   = {shift_byte[6:0], request.sda_in};
  assign buf_rd_idx = (stage == STG_BODY) ? idx_inc : buffer_index;

  // transfer lengths, saturated; a read length of zero becomes one
  always_comb begin
    wr_len = (17'(request.length) > 17'(PAGE_BYTES)) ? 9'(PAGE_BYTES) : request.length;
    rd_len = (17'(request.length) > 17'(MAX_READ_BYTES)) ? 9'(MAX_READ_BYTES)
                                                          : request.length;
    if (rd_len == 9'd0) begin
      rd_len = 9'd1;
    end
  end

  // next state and line levels of one phase
  always_comb begin
    sub_next            = sub;
    stage_next          = stage;
    op_write_next       = op_write;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    buffer_index_next   = buffer_index;
    target_address_next = target_address;
    timeout_count_next  = timeout_count;
    buf_we              = 1'b0;
    scl_c  = 1'b1;
    rel_c  = 1'b1;
    rv_c   = 1'b0;
    rd_c   = 8'd0;
    rl_c   = 1'b0;
    err_c  = 1'b0;
    done_c = 1'b0;

    case (sub)
      PH_IDLE: begin
        stage_next = STG_DEVW;
        case (cmd)
          CMD_LOAD: begin
            buf_we = 1'b1;
          end
          CMD_WRITE, CMD_CUR_READ, CMD_RAND_READ, CMD_SEQ_READ: begin
            op_write_next       = (cmd == CMD_WRITE);
            target_address_next = request.word_address;
            buffer_index_next   = '0;
            timeout_count_next  = 16'd0;
            bit_count_next      = 4'd0;
            if (cmd == CMD_WRITE) begin
              bytes_left_next = wr_len;
            end else if (cmd == CMD_SEQ_READ) begin
              bytes_left_next = rd_len;
            end else begin
              bytes_left_next = 9'd1;
            end
            // current read goes straight to the read address
            if (cmd == CMD_CUR_READ) begin
              shift_byte_next = {device_address, 1'b1};
              stage_next      = STG_DEVR;
            end else begin
              shift_byte_next = {device_address, 1'b0};
            end
            sub_next = PH_TXL;
            rel_c    = 1'b0;
          end
          default: begin
          end
        endcase
      end
      PH_START: begin
        rel_c          = 1'b0;
        bit_count_next = 4'd0;
        sub_next       = PH_TXL;
      end
      PH_TXL: begin
        scl_c    = 1'b0;
        rel_c    = shift_byte[7];
        sub_next = PH_TXH;
      end
      PH_TXH: begin
        rel_c           = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bc_inc >= 4'd8) begin
          bit_count_next     = 4'd0;
          timeout_count_next = 16'd0;
          sub_next           = PH_AKL;
        end else begin
          bit_count_next = bc_inc;
          sub_next       = PH_TXL;
        end
      end
      PH_AKL: begin
        scl_c    = 1'b0;
        sub_next = PH_AKH;
      end
      PH_AKH: begin
        if (!request.sda_in) begin
          timeout_count_next = 16'd0;
          bit_count_next     = 4'd0;
          case (stage)
            STG_DEVW: begin
              shift_byte_next = target_address;
              stage_next      = STG_WORD;
              sub_next        = PH_TXL;
            end
            STG_WORD: begin
              if (op_write) begin
                if (bytes_left == 9'd0) begin
                  stage_next = STG_DEVW;
                  sub_next   = PH_SPA;
                end else begin
                  shift_byte_next = page_buffer[buf_rd_idx];
                  stage_next      = STG_BODY;
                  sub_next        = PH_TXL;
                end
              end else begin
                shift_byte_next = {device_address, 1'b1};
                stage_next      = STG_DEVR;
                sub_next        = PH_RSL;
              end
            end
            STG_BODY: begin
              buffer_index_next = idx_inc;
              bytes_left_next   = bl_dec;
              if (bl_dec == 9'd0) begin
                stage_next = STG_DEVW;
                sub_next   = PH_SPA;
              end else begin
                shift_byte_next = page_buffer[buf_rd_idx];
                sub_next        = PH_TXL;
              end
            end
            default: begin
              shift_byte_next = 8'd0;
              stage_next      = STG_BODY;
              sub_next        = PH_RXL;
            end
          endcase
        end else if (timeout_count >= ack_timeout) begin
          // acknowledge missing too long: stop and flag
          stage_next = STG_ERR;
          sub_next   = PH_SPA;
        end else begin
          timeout_count_next = timeout_count + 16'd1;
        end
      end
      PH_RXL: begin
        scl_c    = 1'b0;
        sub_next = PH_RXH;
      end
      PH_RXH: begin
        shift_byte_next = shift_in;
        if (bc_inc >= 4'd8) begin
          bit_count_next  = 4'd0;
          bytes_left_next = bl_dec;
          rv_c            = 1'b1;
          rd_c            = shift_in;
          rl_c            = (bl_dec == 9'd0);
          sub_next        = PH_MKL;
        end else begin
          bit_count_next = bc_inc;
          sub_next       = PH_RXL;
        end
      end
      PH_MKL: begin
        scl_c    = 1'b0;
        rel_c    = (bytes_left == 9'd0);
        sub_next = PH_MKH;
      end
      PH_MKH: begin
        rel_c = (bytes_left == 9'd0);
        if (bytes_left == 9'd0) begin
          stage_next = STG_DEVW;
          sub_next   = PH_SPA;
        end else begin
          shift_byte_next = 8'd0;
          sub_next        = PH_RXL;
        end
      end
      PH_RSL: begin
        scl_c    = 1'b0;
        sub_next = PH_RSH;
      end
      PH_RSH: begin
        sub_next = PH_START;
      end
      PH_SPA: begin
        scl_c    = 1'b0;
        rel_c    = 1'b0;
        sub_next = PH_SPB;
      end
      PH_SPB: begin
        rel_c    = 1'b0;
        sub_next = PH_SPC;
      end
      PH_SPC: begin
        done_c     = 1'b1;
        err_c      = (stage == STG_ERR);
        stage_next = STG_DEVW;
        sub_next   = PH_IDLE;
      end
      default: begin
        stage_next = STG_DEVW;
        sub_next   = PH_IDLE;
      end
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      sub            <= PH_IDLE;
      stage          <= STG_DEVW;
      op_write       <= 1'b0;
      bit_count      <= 4'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= 9'd0;
      buffer_index   <= '0;
      target_address <= 8'd0;
      timeout_count  <= 16'd0;
    end else if (accept) begin
      sub            <= sub_next;
      stage          <= stage_next;
      op_write       <= op_write_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      buffer_index   <= buffer_index_next;
      target_address <= target_address_next;
      timeout_count  <= timeout_count_next;
    end
  end

  // page buffer load
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      page_buffer[request.load_index[BUF_IDX_W-1:0]] <= request.write_data;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
      ack_timeout    <= ACK_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEV_ADDR:    device_address <= cfg_wr_data[6:0];
        CFG_ACK_TIMEOUT: ack_timeout    <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      scl_r  <= scl_c;
      rel_r  <= rel_c;
      rv_r   <= rv_c;
      rd_r   <= rd_c;
      rl_r   <= rl_c;
      busy_r <= (sub_next != PH_IDLE);
      err_r  <= err_c;
      done_r <= done_c;
    end
  end

  assign result.valid       = out_valid;
  assign result.scl_level   = scl_r;
  assign result.sda_release = rel_r;
  assign result.read_valid  = rv_r;
  assign result.read_data   = rd_r;
  assign result.read_last   = rl_r;
  assign result.busy_res    = busy_r;
  assign result.ack_error   = err_r;
  assign result.done_res    = done_r;

endmodule

// File: rtl/core/i2c_ee_checker.sv
// ---------------------------------------------------------------------------
// i2c_ee_checker
// Port-level checks of the EEPROM bus master, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_ee_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_release,
  input logic       read_valid,
  input logic [7:0] read_data,
  input logic       read_last,
  input logic       busy_res,
  input logic       ack_error,
  input logic       done_res
);

  // a stalled result keeps its contents
  `ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable({scl_level, sda_release, read_valid, read_data, read_last, busy_res, ack_error, done_res}), "result changed while stalled")

  // every request transfer leaves a result behind
  `ASSERT_NEXT(a_in_gives_out, in_valid && in_ready, out_valid, "accepted request gave no result")

  // the stop phase ends with both lines high and the master idle
  `ASSERT_IMPL(a_done_stop, out_valid && done_res, !busy_res && scl_level && sda_release, "transfer end without stop condition")

  // an abort always comes with the end of the transfer
  `ASSERT_IMPL(a_err_done, out_valid && ack_error, done_res, "acknowledge error without stop")

  // a received byte lies inside a transfer, never at its end
  `ASSERT_IMPL(a_read_busy, out_valid && read_valid, busy_res && !done_res, "read byte outside a transfer")

endmodule

bind i2c_eeprom_master_top i2c_ee_checker u_i2c_ee_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (request.valid),
  .in_ready    (request.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .scl_level   (result.scl_level),
  .sda_release (result.sda_release),
  .read_valid  (result.read_valid),
  .read_data   (result.read_data),
  .read_last   (result.read_last),
  .busy_res    (result.busy_res),
  .ack_error   (result.ack_error),
  .done_res    (result.done_res)
);

// File: bench/i2c_eeprom_master_top_tb.sv
// ---------------------------------------------------------------------------
// i2c_eeprom_master_top_tb
// Self-checking bench for the serial EEPROM bus master. A phase predictor
// follows every request transfer and queues the line levels and status it
// should produce. Each result transfer is checked against the oldest entry.
// The request side acts as the EEPROM: it acknowledges at once, late or never, and
// returns random read bits. Stimulus runs under several register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_eeprom_master_top_tb;
  import i2c_ee_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_BUDGET    = 400;
  localparam int NO_ACK         = 70000;

  // command codes the block must ignore
  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wa;
    logic [7:0] wd;
    logic [2:0] li;
    logic [8:0] len;
    logic       sda;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       rel;
    logic       rv;
    logic [7:0] rd;
    logic       last;
    logic       busy;
    logic       err;
    logic       done;
  } res_t;

  // how the emulated slave answers an acknowledge
  typedef enum {ACK_NOW, ACK_MIXED, ACK_ABSENT} ack_mode_t;

  // phase predictor and queue of awaited results
  class bus_phase_board;
    logic [6:0]  dev_addr;
    logic [15:0] timeout;
    phase_t      ph;
    stage_t      stg;
    logic [2:0]  op;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [8:0]  left;
    logic [2:0]  buf_idx;
    logic [7:0]  target;
    logic [15:0] polls;
    logic [7:0]  page [BUF_DEPTH];
    res_t        awaited_phases [$];
    int          mismatches;

    function new();
      dev_addr   = DEV_ADDR_RESET;
      timeout    = ACK_TIMEOUT_RESET;
      ph         = PH_IDLE;
      stg        = STG_DEVW;
      op         = '0;
      bit_cnt    = '0;
      shreg      = '0;
      left       = '0;
      buf_idx    = '0;
      target     = '0;
      polls      = '0;
      mismatches = 0;
    endfunction

    function void go(stage_t s, phase_t p);
      stg = s;
      ph  = p;
    endfunction

    function void set_register(logic idx, logic [15:0] val);
      if (idx == CFG_DEV_ADDR) begin
        dev_addr = val[6:0];
      end else begin
        timeout = val;
      end
    endfunction

    function string show(res_t v);
      return $sformatf("scl %0b sda %0b valid %0b data %02h last %0b busy %0b err %0b done %0b",
                       v.scl, v.rel, v.rv, v.rd, v.last, v.busy, v.err, v.done);
    endfunction

    // advance one bus phase and queue what the block should report
    function void note_request(req_t r);
      res_t e;
      e     = '0;
      e.scl = 1'b1;
      e.rel = 1'b1;
      case (ph)
        PH_IDLE: begin
          stg = STG_DEVW;
          if (r.cmd == CMD_LOAD) begin
            page[r.li] = r.wd;
          end else if (r.cmd >= CMD_WRITE && r.cmd <= CMD_SEQ_READ) begin
            op      = r.cmd;
            target  = r.wa;
            buf_idx = '0;
            polls   = '0;
            bit_cnt = '0;
            if (r.cmd == CMD_WRITE) begin
              left = (r.len > 9'(PAGE_BYTES)) ? 9'(PAGE_BYTES) : r.len;
            end else if (r.cmd == CMD_SEQ_READ) begin
              left = (r.len > 9'(MAX_READ_BYTES)) ? 9'(MAX_READ_BYTES) : r.len;
              if (left == 0) left = 9'd1;
            end else begin
              left = 9'd1;
            end
            if (r.cmd == CMD_CUR_READ) begin
              shreg = {dev_addr, 1'b1};
              go(STG_DEVR, PH_TXL);
            end else begin
              shreg = {dev_addr, 1'b0};
              go(STG_DEVW, PH_TXL);
            end
            e.rel = 1'b0;
          end
        end
        PH_START: begin
          e.rel   = 1'b0;
          bit_cnt = '0;
          ph      = PH_TXL;
        end
        PH_TXL: begin
          e.scl = 1'b0;
          e.rel = shreg[7];
          ph    = PH_TXH;
        end
        PH_TXH: begin
          e.rel   = shreg[7];
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            polls   = '0;
            ph      = PH_AKL;
          end else begin
            ph = PH_TXL;
          end
        end
        PH_AKL: begin
          e.scl = 1'b0;
          ph    = PH_AKH;
        end
        PH_AKH: begin
          if (r.sda == 1'b0) begin
            polls   = '0;
            bit_cnt = '0;
            case (stg)
              STG_DEVW: begin
                shreg = target;
                go(STG_WORD, PH_TXL);
              end
              STG_WORD: begin
                if (op == CMD_WRITE) begin
                  if (left == 0) begin
                    go(STG_DEVW, PH_SPA);
                  end else begin
                    shreg = page[buf_idx];
                    go(STG_BODY, PH_TXL);
                  end
                end else begin
                  shreg = {dev_addr, 1'b1};
                  go(STG_DEVR, PH_RSL);
                end
              end
              STG_BODY: begin
                buf_idx = buf_idx + 3'd1;
                if (left != 0) left = left - 9'd1;
                if (left == 0) begin
                  go(STG_DEVW, PH_SPA);
                end else begin
                  shreg = page[buf_idx];
                  go(STG_BODY, PH_TXL);
                end
              end
              default: begin
                shreg = '0;
                go(STG_BODY, PH_RXL);
              end
            endcase
          end else if (polls >= timeout) begin
            go(STG_ERR, PH_SPA);
          end else begin
            polls = polls + 16'd1;
          end
        end
        PH_RXL: begin
          e.scl = 1'b0;
          ph    = PH_RXH;
        end
        PH_RXH: begin
          shreg   = {shreg[6:0], r.sda};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            if (left != 0) left = left - 9'd1;
            e.rv   = 1'b1;
            e.rd   = shreg;
            e.last = (left == 0);
            ph     = PH_MKL;
          end else begin
            ph = PH_RXL;
          end
        end
        PH_MKL: begin
          e.scl = 1'b0;
          e.rel = (left == 0);
          ph    = PH_MKH;
        end
        PH_MKH: begin
          e.rel = (left == 0);
          if (left == 0) begin
            go(STG_DEVW, PH_SPA);
          end else begin
            shreg = '0;
            ph    = PH_RXL;
          end
        end
        PH_RSL: begin
          e.scl = 1'b0;
          ph    = PH_RSH;
        end
        PH_RSH: begin
          ph = PH_START;
        end
        PH_SPA: begin
          e.scl = 1'b0;
          e.rel = 1'b0;
          ph    = PH_SPB;
        end
        PH_SPB: begin
          e.rel = 1'b0;
          ph    = PH_SPC;
        end
        PH_SPC: begin
          e.done = 1'b1;
          e.err  = (stg == STG_ERR);
          go(STG_DEVW, PH_IDLE);
        end
        default: begin
          go(STG_DEVW, PH_IDLE);
        end
      endcase
      e.busy = (ph != PH_IDLE);
      awaited_phases.push_back(e);
    endfunction

    // compare one result transfer with the oldest awaited phase
    function void check_result(res_t got);
      res_t e;
      if (awaited_phases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing awaited: %s", show(got));
        return;
      end
      e = awaited_phases.pop_front();
      if (got.scl !== e.scl || got.rel !== e.rel || got.rv !== e.rv || got.rd !== e.rd ||
          got.last !== e.last || got.busy !== e.busy || got.err !== e.err ||
          got.done !== e.done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("bus phase mismatch at %0t: expected %s, got %s", $time, show(e), show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wr_data;
  logic        res_ready = 1'b0;
  bit          calm_req  = 1'b0;
  bit          calm_res  = 1'b0;
  int          res_stall = 0;
  int          stall_draw;
  int          idle_cycles = 0;
  int          ack_hold = 0;
  int          items_sent = 0;
  ack_mode_t   ack_mode = ACK_NOW;

  bus_phase_board sb = new();

  i2c_ee_req_if req_ch ();
  i2c_ee_res_if res_ch ();

  assign res_ch.ready = res_ready;

  i2c_eeprom_master_top uut (
    .clk         (clk),
    .rst         (rst),
    .request     (req_ch),
    .result      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // transfer length, kept short so each transfer costs few phases
  function automatic logic [8:0] pick_length(input logic [2:0] cmd);
    int r;
    r = $urandom_range(0, 99);
    if (cmd == CMD_WRITE) begin
      if (r < 10) return 9'd0;
      if (r < 70) return 9'($urandom_range(1, 3));
      if (r < 90) return 9'($urandom_range(4, PAGE_BYTES));
      return 9'($urandom_range(PAGE_BYTES + 1, 511));
    end
    if (cmd == CMD_SEQ_READ) begin
      if (r < 10) return 9'd0;
      if (r < 75) return 9'($urandom_range(1, 2));
      return 9'($urandom_range(3, 6));
    end
    return 9'($urandom_range(0, 511));
  endfunction

  // one request transfer; sda comes from the emulated slave
  task automatic issue(input logic [2:0] cmd, input logic [7:0] wa, input logic [7:0] wd,
                       input logic [2:0] li, input logic [8:0] len);
    req_t r;
    int   gap;
    int   pick;
    r.cmd = cmd;
    r.wa  = wa;
    r.wd  = wd;
    r.li  = li;
    r.len = len;
    r.sda = 1'($urandom_range(0, 1));
    // decide how long the slave holds off the coming acknowledge
    if (sb.ph == PH_AKL) begin
      pick = $urandom_range(0, 99);
      if (ack_mode == ACK_NOW) ack_hold = 0;
      else if (ack_mode == ACK_ABSENT) ack_hold = NO_ACK;
      else if (pick < 75) ack_hold = 0;
      else if (pick < 88 || sb.timeout > 16'd256) ack_hold = $urandom_range(1, 3);
      else if (pick < 96) ack_hold = int'(sb.timeout) + $urandom_range(0, 1);
      else ack_hold = NO_ACK;
    end else if (sb.ph == PH_AKH) begin
      r.sda = (int'(sb.polls) < ack_hold);
    end
    if ($urandom_range(0, 299) == 0) calm_req = !calm_req;
    gap = calm_req ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.command      <= r.cmd;
    req_ch.word_address <= r.wa;
    req_ch.write_data   <= r.wd;
    req_ch.load_index   <= r.li;
    req_ch.length       <= r.len;
    req_ch.sda_in       <= r.sda;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    items_sent++;
  endtask

  // tick until the transfer ends, with the odd command thrown in
  task automatic finish_transfer();
    logic [2:0] cmd;
    while (sb.ph != PH_IDLE) begin
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_LOAD, CMD_BAD_HI)) : CMD_TICK;
      issue(cmd, 8'($urandom), 8'($urandom), 3'($urandom), 9'($urandom));
    end
  endtask

  task automatic run_transfer(input logic [2:0] cmd, input logic [7:0] wa,
                              input logic [8:0] len);
    issue(cmd, wa, 8'($urandom), 3'($urandom), len);
    finish_transfer();
  endtask

  // wait until every awaited result has arrived and the block is quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.awaited_phases.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] dev, input logic [15:0] tmo);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_DEV_ADDR;
    cfg_wr_data <= {9'd0, dev};
    @(posedge clk);
    sb.set_register(CFG_DEV_ADDR, {9'd0, dev});
    cfg_index   <= CFG_ACK_TIMEOUT;
    cfg_wr_data <= tmo;
    @(posedge clk);
    sb.set_register(CFG_ACK_TIMEOUT, tmo);
    cfg_wr_en <= 1'b0;
  endtask

  // fill the page buffer, then short transfers and the edge cases
  task automatic directed_part();
    logic [7:0] fill [8] = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h80, 8'h7e, 8'h3c};
    ack_mode = ACK_NOW;
    for (int i = 0; i < 8; i++) issue(CMD_LOAD, 8'h00, fill[i], 3'(i), 9'd1);
    run_transfer(CMD_WRITE, 8'h00, 9'd0);
    run_transfer(CMD_CUR_READ, 8'h00, 9'd1);
    run_transfer(CMD_SEQ_READ, 8'h00, 9'd0);
    issue(CMD_BAD_LO, 8'h12, 8'h34, 3'd5, 9'd7);
    issue(CMD_BAD_HI, 8'hed, 8'hcb, 3'd2, 9'd7);
    // slave never answers: timeout, stop and error
    settle();
    configure(DEV_ADDR_RESET, 16'd3);
    ack_mode = ACK_ABSENT;
    run_transfer(CMD_WRITE, 8'h11, 9'd2);
  endtask

  // random commands while idle, each transfer run to its stop
  task automatic random_phase(input int item_target);
    int         pick;
    logic [2:0] cmd;
    ack_mode = ACK_MIXED;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd = CMD_LOAD;
      else if (pick < 38) cmd = CMD_WRITE;
      else if (pick < 48) cmd = CMD_CUR_READ;
      else if (pick < 60) cmd = CMD_RAND_READ;
      else if (pick < 85) cmd = CMD_SEQ_READ;
      else if (pick < 92) cmd = $urandom_range(0, 1) ? CMD_BAD_LO : CMD_BAD_HI;
      else cmd = CMD_TICK;
      issue(cmd, 8'($urandom), 8'($urandom), 3'($urandom), pick_length(cmd));
      finish_transfer();
    end while (items_sent < item_target);
  endtask

  task automatic run_setting(input logic [6:0] dev, input logic [15:0] tmo,
                             input int item_target);
    settle();
    configure(dev, tmo);
    random_phase(item_target);
  endtask

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result({res_ch.scl_level, res_ch.sda_release, res_ch.read_valid,
                       res_ch.read_data, res_ch.read_last, res_ch.busy_res,
                       res_ch.ack_error, res_ch.done_res});
    end
    if ($urandom_range(0, 299) == 0) calm_res <= !calm_res;
    if (res_stall > 0) begin
      res_ready <= 1'b0;
      res_stall <= res_stall - 1;
    end else if (calm_res) begin
      res_ready <= 1'b1;
    end else begin
      stall_draw = pick_gap();
      res_ready <= (stall_draw == 0);
      if (stall_draw > 0) res_stall <= stall_draw - 1;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.command      <= CMD_TICK;
    req_ch.word_address <= '0;
    req_ch.write_data   <= '0;
    req_ch.load_index   <= '0;
    req_ch.length       <= '0;
    req_ch.sda_in       <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_DEV_ADDR;
    cfg_wr_data         <= '0;
    rst                 <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_part();
    run_setting(7'd0, 16'd1, 250);
    run_setting(7'd127, 16'd0, 300);
    run_setting(7'h2a, 16'hffff, 340);
    run_setting(7'($urandom), 16'($urandom_range(2, 20)), ITEM_BUDGET);
    settle();

    if (sb.mismatches == 0 && sb.awaited_phases.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/i2c_ee_pkg.sv
rtl/core/i2c_ee_req_if.sv
rtl/core/i2c_ee_res_if.sv
rtl/core/i2c_eeprom_master_top.sv
rtl/core/i2c_ee_checker.sv
bench/i2c_eeprom_master_top_tb.sv
